[rtl/prg_pkg.sv]
package prg_pkg;

	localparam int VALUE_BITS = 16;
	localparam int MAX_RUN    = 64;

	localparam int START_BITS = 16;
	localparam int SKIP_BITS  = 13;
	localparam int WANT_BITS  = 7;

	localparam int DIV_BITS  = (VALUE_BITS + 1) / 2;
	localparam int NUM_CELLS = 2 ** (DIV_BITS - 1) - 1;
	localparam int CNT_BITS  = $clog2(VALUE_BITS);
	localparam int RUN_BITS  = $clog2(MAX_RUN + 1);
	localparam int CMP_BITS  = (VALUE_BITS > START_BITS) ? VALUE_BITS : START_BITS;

	localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

	typedef enum logic [1:0] {
		OP_IDLE,
		OP_LOAD,
		OP_TEST,
		OP_END
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic                  ld_bit;
		logic [VALUE_BITS-1:0] cand;
		logic                  hit;
	} prg_link_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SEARCH,
		ST_DRAIN
	} state_t;

endpackage

[rtl/prime_run_generator.sv]
// Channel   Handshake                Fields
// request   start in, busy out       start_after, skip_count, count_wanted
// result    result_strobe out        prime_value, last_of_run, overrun
//
// A request loads its start value into the divisor cells one bit a cycle,
// then feeds one candidate a cycle into a row of NUM_CELLS odd-divisor
// cells; each verdict leaves the row after passing every cell's register.
// Reset clears all control; the receiver cannot stall, so each result
// stands for one cycle only.
module prime_run_generator
	import prg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [START_BITS-1:0] start_after,
	input  logic [SKIP_BITS-1:0]  skip_count,
	input  logic [WANT_BITS-1:0]  count_wanted,
	output logic                  busy,
	output logic                  result_strobe,
	output logic [VALUE_BITS-1:0] prime_value,
	output logic                  last_of_run,
	output logic                  overrun
);

	state_t                state_q;
	state_t                state_nx;
	logic [VALUE_BITS-1:0] cand_q;
	logic [VALUE_BITS-1:0] bits_q;
	logic [CNT_BITS-1:0]   bitcnt_q;
	logic [SKIP_BITS-1:0]  skip_q;
	logic [RUN_BITS-1:0]   left_q;
	logic                  done_q;
	logic                  strobe_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  last_q;
	logic                  over_q;

	logic                  accept;
	logic                  start_high;
	logic [RUN_BITS-1:0]   want_sat;
	logic                  search_end;
	logic                  is_prime;
	logic                  emit_prime;
	logic                  emit_over;
	prg_link_t             inject;
	prg_link_t             tail;

	assign accept     = start && !busy;
	assign start_high = CMP_BITS'(start_after) >= CMP_BITS'(VALUE_MAX);
	assign want_sat   = (count_wanted > WANT_BITS'(MAX_RUN)) ?
		RUN_BITS'(MAX_RUN) : RUN_BITS'(count_wanted);
	assign search_end = (cand_q == VALUE_MAX) || done_q;
	assign is_prime   = (tail.cand >= VALUE_BITS'(2)) && !tail.hit &&
		(tail.cand[0] || (tail.cand == VALUE_BITS'(2)));
	assign emit_prime = (tail.op == OP_TEST) && !done_q && is_prime && (skip_q == '0);
	assign emit_over  = (tail.op == OP_END) && !done_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (count_wanted != '0)) state_nx = ST_LOAD;
			end
			ST_LOAD: begin
				if (bitcnt_q == CNT_BITS'(VALUE_BITS - 1)) state_nx = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (search_end) state_nx = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (tail.op == OP_END) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		busy          = (state_q != ST_IDLE);
		inject.op     = OP_IDLE;
		inject.ld_bit = bits_q[VALUE_BITS-1];
		inject.cand   = cand_q + VALUE_BITS'(1);
		inject.hit    = 1'b0;
		case (state_q)
			ST_LOAD:   inject.op = OP_LOAD;
			ST_SEARCH: inject.op = search_end ? OP_END : OP_TEST;
			default:   inject.op = OP_IDLE;
		endcase
	end

	prg_chain u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.link_in  (inject),
		.link_out (tail)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			bitcnt_q <= '0;
			done_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_nx;
			strobe_q <= emit_prime || emit_over;
			case (state_q)
				ST_IDLE: begin
					bitcnt_q <= '0;
					done_q   <= 1'b0;
				end
				ST_LOAD: begin
					bitcnt_q <= bitcnt_q + CNT_BITS'(1);
				end
				default: begin
					bitcnt_q <= bitcnt_q;
					if (emit_prime && (left_q == RUN_BITS'(1))) done_q <= 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cand_q <= start_high ? VALUE_MAX : VALUE_BITS'(start_after);
					bits_q <= start_high ? VALUE_MAX : VALUE_BITS'(start_after);
					skip_q <= skip_count;
					left_q <= want_sat;
				end
			end
			ST_LOAD: begin
				bits_q <= {bits_q[VALUE_BITS-2:0], 1'b0};
			end
			ST_SEARCH: begin
				if (!search_end) cand_q <= cand_q + VALUE_BITS'(1);
			end
			default: begin
				cand_q <= cand_q;
			end
		endcase
		if ((tail.op == OP_TEST) && !done_q && is_prime) begin
			if (skip_q != '0) begin
				skip_q <= skip_q - SKIP_BITS'(1);
			end else begin
				left_q  <= left_q - RUN_BITS'(1);
				value_q <= tail.cand;
				last_q  <= (left_q == RUN_BITS'(1));
				over_q  <= 1'b0;
			end
		end
		if (emit_over) begin
			value_q <= '0;
			last_q  <= 1'b1;
			over_q  <= 1'b1;
		end
	end

	assign result_strobe = strobe_q;
	assign prime_value   = value_q;
	assign last_of_run   = last_q;
	assign overrun       = over_q;

endmodule

[rtl/prg_cell.sv]
module prg_cell
	import prg_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [DIV_BITS-1:0] divisor,
	input  prg_link_t           link_in,
	output prg_link_t           link_out
);

	logic [DIV_BITS-1:0]   residue_q;
	logic [DIV_BITS-1:0]   residue_inc;
	logic [DIV_BITS:0]     residue_sh;
	logic [DIV_BITS-1:0]   residue_ld;
	logic                  divides;
	op_t                   op_q;
	logic                  ld_bit_q;
	logic [VALUE_BITS-1:0] cand_q;
	logic                  hit_q;

	assign residue_inc = (residue_q == divisor - DIV_BITS'(1)) ? '0 : residue_q + DIV_BITS'(1);
	assign residue_sh  = {residue_q, link_in.ld_bit};
	assign residue_ld  = (residue_sh >= {1'b0, divisor}) ?
		DIV_BITS'(residue_sh - {1'b0, divisor}) : DIV_BITS'(residue_sh);
	assign divides     = (residue_inc == '0) && (link_in.cand != VALUE_BITS'(divisor));

	// clear while idle so each load starts from zero
	always_ff @(posedge clk) begin
		case (link_in.op)
			OP_IDLE: residue_q <= '0;
			OP_LOAD: residue_q <= residue_ld;
			OP_TEST: residue_q <= residue_inc;
			default: residue_q <= residue_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_IDLE;
		end else begin
			op_q <= link_in.op;
		end
	end

	always_ff @(posedge clk) begin
		ld_bit_q <= link_in.ld_bit;
		cand_q   <= link_in.cand;
		hit_q    <= link_in.hit | ((link_in.op == OP_TEST) && divides);
	end

	assign link_out.op     = op_q;
	assign link_out.ld_bit = ld_bit_q;
	assign link_out.cand   = cand_q;
	assign link_out.hit    = hit_q;

endmodule

[rtl/prg_chain.sv]
module prg_chain
	import prg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  prg_link_t link_in,
	output prg_link_t link_out
);

	prg_link_t links [NUM_CELLS+1];

	assign links[0] = link_in;

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		logic [DIV_BITS-1:0] divisor;

		assign divisor = DIV_BITS'(2 * i + 3);

		prg_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.divisor  (divisor),
			.link_in  (links[i]),
			.link_out (links[i+1])
		);
	end

	assign link_out = links[NUM_CELLS];

endmodule
